// ----- rtl/oled_pkg.sv -----
package oled_pkg;

    // display ram geometry
    localparam int COLUMNS = 128;
    localparam int PAGES   = 16;

    // request codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // command opcodes
    localparam logic [7:0] OP_CONTRAST   = 8'h81;
    localparam logic [7:0] OP_MUX        = 8'ha8;
    localparam logic [7:0] OP_DCDC       = 8'had;
    localparam logic [7:0] OP_OFFSET     = 8'hd3;
    localparam logic [7:0] OP_CLKDIV     = 8'hd5;
    localparam logic [7:0] OP_PRECHARGE  = 8'hd9;
    localparam logic [7:0] OP_PINS       = 8'hda;
    localparam logic [7:0] OP_VCOM       = 8'hdb;
    localparam logic [7:0] OP_START_LINE = 8'hdc;
    localparam logic [7:0] OP_DISP_OFF   = 8'hae;
    localparam logic [7:0] OP_DISP_ON    = 8'haf;
    localparam logic [7:0] OP_NORMAL     = 8'ha6;
    localparam logic [7:0] OP_INVERT     = 8'ha7;
    localparam logic [7:0] OP_PAGE_MODE  = 8'h20;
    localparam logic [7:0] OP_VERT_MODE  = 8'h21;
    localparam logic [7:0] OP_SCAN_INC   = 8'hc0;
    localparam logic [7:0] OP_SCAN_DEC   = 8'hc8;
    localparam logic [7:0] OP_SEG_NORMAL = 8'ha0;
    localparam logic [7:0] OP_SEG_REMAP  = 8'ha1;

    localparam logic [6:0] COL_OFFSET_RESET = 7'd96;
    localparam logic [7:0] CONTRAST_RESET   = 8'd127;

    // commands from controller to datapath
    typedef struct packed {
        logic       clear_en;   // clearing sweep write
        logic [6:0] col;        // column pointer
        logic [3:0] page;       // page pointer
        logic       store_en;   // store data byte
        logic [7:0] store_data;
        logic       read_en;    // pixel read
        logic [6:0] read_x;
        logic [6:0] read_y;
    } dp_cmd_t;

    // status back to controller
    typedef struct packed {
        logic       out_valid;
    } dp_sts_t;

    function automatic logic takes_param(input logic [7:0] op);
        case (op)
            OP_CONTRAST, OP_MUX, OP_DCDC, OP_OFFSET, OP_CLKDIV,
            OP_PRECHARGE, OP_PINS, OP_VCOM, OP_START_LINE: takes_param = 1'b1;
            default: takes_param = 1'b0;
        endcase
    endfunction

endpackage

// ----- rtl/oled_datapath.sv -----
module oled_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  oled_pkg::dp_cmd_t cmd,
    input  logic              remap_segments,
    input  logic              rows_reversed,
    input  logic              inverted,
    input  logic              panel_on,
    input  logic [7:0]        first_line,
    input  logic [6:0]        column_offset,
    input  logic [7:0]        contrast,
    input  logic              m_ready,
    output logic              m_valid,
    output logic              m_pixel_on,
    output logic [7:0]        m_contrast_level,
    output oled_pkg::dp_sts_t sts
);
    localparam int COLUMNS = oled_pkg::COLUMNS;
    localparam int PAGES   = oled_pkg::PAGES;
    localparam int CW = $clog2(COLUMNS);
    localparam int PW = $clog2(PAGES);
    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW = CW + PW;

    logic [7:0] ram [DEPTH];

    // write address
    logic           wr_ok;
    logic [6:0]     wr_col;
    logic [AW-1:0]  wr_addr;
    logic [7:0]     wr_data;
    logic           wr_en;
    always_comb begin
        wr_ok  = ({25'd0, cmd.col} < COLUMNS) && ({28'd0, cmd.page} < PAGES);
        wr_col = remap_segments ? 7'(COLUMNS - 1 - int'(cmd.col)) : cmd.col;
        wr_addr = {cmd.page[PW-1:0], wr_col[CW-1:0]};
        wr_en   = cmd.clear_en || (cmd.store_en && wr_ok);
        wr_data = cmd.clear_en ? 8'd0 : cmd.store_data;
    end

    // read address
    logic [7:0]    s_row;
    logic [7:0]    v_row;
    logic [7:0]    r_col;
    logic          rd_ok;
    logic [AW-1:0] rd_addr;
    always_comb begin
        s_row = 8'((9'(cmd.read_y) + 9'(first_line)) % COLUMNS);
        v_row = rows_reversed ? 8'(COLUMNS - 1 - int'(s_row)) : s_row;
        r_col = 8'((9'(cmd.read_x) + 9'(column_offset)) % COLUMNS);
        rd_ok = ({27'd0, v_row[7:3]} < PAGES);
        rd_addr = {v_row[PW+2:3], r_col[CW-1:0]};
    end

    logic [7:0] rd_byte_reg;
    logic [2:0] bit_sel_reg;
    logic       rd_ok_reg;
    logic       out_pending_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram[wr_addr] <= wr_data;
        end
        if (cmd.read_en) begin
            rd_byte_reg <= ram[rd_addr];
            bit_sel_reg <= v_row[2:0];
            rd_ok_reg   <= rd_ok;
        end
    end

    // result stage, loads once the output register is free
    logic out_pending_next;
    logic pix;
    logic capture;
    always_comb begin
        pix = rd_ok_reg && rd_byte_reg[bit_sel_reg];
        capture = out_pending_reg && (!m_valid || m_ready);
        out_pending_next = out_pending_reg;
        if (cmd.read_en) out_pending_next = 1'b1;
        else if (capture) out_pending_next = 1'b0;
    end

    logic       m_valid_reg;
    logic       pixel_reg;
    logic [7:0] contrast_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_pending_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            out_pending_reg <= out_pending_next;
            if (capture) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (capture) begin
            pixel_reg    <= (pix != inverted) && panel_on;
            contrast_reg <= contrast;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pixel_on       = pixel_reg;
    assign m_contrast_level = contrast_reg;
    assign sts.out_valid    = out_pending_reg;
endmodule

// ----- rtl/oled_ctrl.sv -----
module oled_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [7:0]        s_data_byte,
    input  logic [6:0]        s_pixel_x,
    input  logic [6:0]        s_pixel_y,
    input  oled_pkg::dp_sts_t sts,
    output oled_pkg::dp_cmd_t cmd,
    output logic              remap_segments,
    output logic              rows_reversed,
    output logic              inverted,
    output logic              panel_on,
    output logic [7:0]        first_line,
    output logic [7:0]        contrast
);
    localparam int COLUMNS = oled_pkg::COLUMNS;
    localparam int PAGES   = oled_pkg::PAGES;
    localparam int DEPTH = COLUMNS * PAGES;
    localparam int CW = $clog2(COLUMNS);
    localparam int AW = $clog2(DEPTH);

    typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_WAIT} state_t;

    state_t     state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [6:0] col_reg, col_next;
    logic [3:0] page_reg, page_next;
    logic       vert_reg, vert_next;
    logic       remap_reg, remap_next;
    logic       rowrev_reg, rowrev_next;
    logic       inv_reg, inv_next;
    logic       on_reg, on_next;
    logic [7:0] line_reg, line_next;
    logic [7:0] contrast_reg, contrast_next;
    logic [4:0] clkdiv_reg, clkdiv_next;
    logic [3:0] pre1_reg, pre1_next;
    logic [3:0] pre2_reg, pre2_next;
    logic       expect_reg, expect_next;
    logic       cmdmode_reg, cmdmode_next;
    logic       cont_reg, cont_next;
    logic [7:0] pend_reg, pend_next;
    logic       await_reg, await_next;

    logic       accept;
    logic       do_cmd;
    logic [7:0] op, arg;
    logic [7:0] ccol;
    logic [4:0] cpage;

    assign s_ready = (state_reg == ST_RUN);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        col_next = col_reg; page_next = page_reg; vert_next = vert_reg;
        remap_next = remap_reg; rowrev_next = rowrev_reg; inv_next = inv_reg;
        on_next = on_reg; line_next = line_reg; contrast_next = contrast_reg;
        clkdiv_next = clkdiv_reg; pre1_next = pre1_reg; pre2_next = pre2_reg;
        expect_next = expect_reg; cmdmode_next = cmdmode_reg; cont_next = cont_reg;
        pend_next = pend_reg; await_next = await_reg;
        do_cmd = 1'b0; op = s_data_byte; arg = 8'd0;
        ccol = 8'(col_reg); cpage = 5'(page_reg);

        cmd = '0;
        cmd.col = col_reg;
        cmd.page = page_reg;
        cmd.store_data = s_data_byte;
        cmd.read_x = s_pixel_x;
        cmd.read_y = s_pixel_y;

        case (state_reg)
            // clear sweep after reset
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                cmd.col  = 7'(clr_reg[CW-1:0]);
                cmd.page = 4'(clr_reg >> CW);
                // clear writes the raw address; remap_segments is held off during the sweep
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == DEPTH - 1) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (accept) begin
                    case (s_req_type)
                        oled_pkg::REQ_START: expect_next = 1'b1;
                        oled_pkg::REQ_WRITE: begin
                            if (expect_reg) begin
                                cmdmode_next = !s_data_byte[6];
                                cont_next    = !s_data_byte[7];
                                expect_next  = 1'b0;
                            end else begin
                                if (cmdmode_reg) begin
                                    if (await_reg) begin
                                        await_next = 1'b0;
                                        op = pend_reg; arg = s_data_byte; do_cmd = 1'b1;
                                    end else if (oled_pkg::takes_param(s_data_byte)) begin
                                        pend_next = s_data_byte;
                                        await_next = 1'b1;
                                    end else begin
                                        do_cmd = 1'b1;
                                    end
                                end else begin
                                    cmd.store_en = 1'b1;
                                    if (!vert_reg) begin
                                        ccol = ccol + 8'd1;
                                        if (32'(ccol) >= COLUMNS) ccol = 8'd0;
                                    end else begin
                                        cpage = cpage + 5'd1;
                                        if (32'(cpage) >= PAGES) begin
                                            cpage = 5'd0;
                                            ccol = ccol + 8'd1;
                                            if (32'(ccol) >= COLUMNS) ccol = 8'd0;
                                        end
                                    end
                                    col_next  = ccol[6:0];
                                    page_next = cpage[3:0];
                                end
                                if (!cont_reg && !(cmdmode_reg && !await_reg
                                        && oled_pkg::takes_param(s_data_byte)))
                                    expect_next = 1'b1;
                            end
                        end
                        oled_pkg::REQ_READ: begin
                            cmd.read_en = 1'b1;
                            state_next = ST_WAIT;
                        end
                        default: ;
                    endcase
                end
            end
            // hold until the pixel is loaded into the output register
            ST_WAIT: begin
                if (!sts.out_valid) state_next = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase

        // command decode
        if (do_cmd) begin
            case (op)
                oled_pkg::OP_CONTRAST:   contrast_next = arg;
                oled_pkg::OP_DISP_OFF:   on_next = 1'b0;
                oled_pkg::OP_DISP_ON:    on_next = 1'b1;
                oled_pkg::OP_NORMAL:     inv_next = 1'b0;
                oled_pkg::OP_INVERT:     inv_next = 1'b1;
                oled_pkg::OP_PAGE_MODE:  vert_next = 1'b0;
                oled_pkg::OP_VERT_MODE:  vert_next = 1'b1;
                oled_pkg::OP_CLKDIV:     clkdiv_next = 5'd1 + 5'(arg[3:0]);
                oled_pkg::OP_PRECHARGE: begin
                    pre1_next = arg[3:0];
                    pre2_next = arg[7:4];
                end
                oled_pkg::OP_SCAN_INC:   rowrev_next = 1'b0;
                oled_pkg::OP_SCAN_DEC:   rowrev_next = 1'b1;
                oled_pkg::OP_SEG_NORMAL: remap_next = 1'b0;
                oled_pkg::OP_SEG_REMAP:  remap_next = 1'b1;
                oled_pkg::OP_START_LINE: line_next = arg;
                default: begin
                    if (op[7:4] == 4'h0) col_next = {col_reg[6:4], op[3:0]};
                    else if (op[7:3] == 5'b00010) col_next = {op[2:0], col_reg[3:0]};
                    else if (op[7:4] == 4'hb) page_next = op[3:0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            col_reg <= '0; page_reg <= '0; vert_reg <= 1'b0;
            remap_reg <= 1'b0; rowrev_reg <= 1'b0; inv_reg <= 1'b0; on_reg <= 1'b0;
            line_reg <= '0; contrast_reg <= oled_pkg::CONTRAST_RESET;
            clkdiv_reg <= 5'd1; pre1_reg <= 4'd2; pre2_reg <= 4'd2;
            expect_reg <= 1'b1; cmdmode_reg <= 1'b0; cont_reg <= 1'b0;
            pend_reg <= '0; await_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            col_reg <= col_next; page_reg <= page_next; vert_reg <= vert_next;
            remap_reg <= remap_next; rowrev_reg <= rowrev_next; inv_reg <= inv_next;
            on_reg <= on_next; line_reg <= line_next; contrast_reg <= contrast_next;
            clkdiv_reg <= clkdiv_next; pre1_reg <= pre1_next; pre2_reg <= pre2_next;
            expect_reg <= expect_next; cmdmode_reg <= cmdmode_next; cont_reg <= cont_next;
            pend_reg <= pend_next; await_reg <= await_next;
        end
    end

    // remap off during the sweep so every raw address is covered
    assign remap_segments = remap_reg && (state_reg != ST_CLEAR);
    assign rows_reversed  = rowrev_reg;
    assign inverted       = inv_reg;
    assign panel_on       = on_reg;
    assign first_line     = line_reg;
    assign contrast       = contrast_reg;

    // clock divider and precharge are held in registers but not used by this block
    logic unused_drive;
    assign unused_drive = ^{clkdiv_reg, pre1_reg, pre2_reg};
endmodule

// ----- rtl/monochrome_oled_display_controller.sv -----
// channel   | direction | handshake          | payload
// s_        | in        | s_valid / s_ready  | req_type, data_byte, pixel_x, pixel_y
// m_        | out       | m_valid / m_ready  | pixel_on, contrast_level
// apb       | in        | psel/penable/pready| column_offset at address 0
//
// start and write items are taken back to back; after a pixel read s_ready
// drops in ST_WAIT while the ram byte is read and loaded into the output
// register, and ST_RUN takes the next item once that load is done
// after reset the display ram is swept to zero while s_ready stays low;
// configuration writes are taken
// a result stalled on m_ready lets the next pixel read in but holds back every item after it
module monochrome_oled_display_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_data_byte,
    input  logic [6:0]  s_pixel_x,
    input  logic [6:0]  s_pixel_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_pixel_on,
    output logic [7:0]  m_contrast_level,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    oled_pkg::dp_cmd_t cmd;
    oled_pkg::dp_sts_t sts;
    logic       remap_segments, rows_reversed, inverted, panel_on;
    logic [7:0] first_line, contrast;

    // configuration register
    logic [6:0] col_offset_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_offset_reg <= oled_pkg::COL_OFFSET_RESET;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            col_offset_reg <= pwdata[6:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {25'd0, col_offset_reg} : 32'd0;

    oled_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_data_byte(s_data_byte),
        .s_pixel_x(s_pixel_x), .s_pixel_y(s_pixel_y),
        .sts(sts), .cmd(cmd),
        .remap_segments(remap_segments), .rows_reversed(rows_reversed),
        .inverted(inverted), .panel_on(panel_on),
        .first_line(first_line), .contrast(contrast)
    );

    oled_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .remap_segments(remap_segments), .rows_reversed(rows_reversed),
        .inverted(inverted), .panel_on(panel_on), .first_line(first_line),
        .column_offset(col_offset_reg), .contrast(contrast),
        .m_ready(m_ready), .m_valid(m_valid),
        .m_pixel_on(m_pixel_on), .m_contrast_level(m_contrast_level),
        .sts(sts)
    );
endmodule

// ----- tb/sv/monochrome_oled_display_controller_test.sv -----
`timescale 1ns / 1ps

module monochrome_oled_display_controller_test;

    localparam logic [1:0] REQ_RESERVED    = 2'd3;
    localparam logic [1:0] ADDR_COL_OFFSET = 2'd0;
    localparam logic [7:0] OP_COL_LOW      = 8'h00;
    localparam logic [7:0] OP_COL_HIGH     = 8'h10;
    localparam logic [7:0] OP_PAGE_BASE    = 8'hb0;
    localparam logic [7:0] CTRL_SINGLE     = 8'h80;
    localparam logic [7:0] CTRL_DATA       = 8'h40;
    localparam int         IDLE_LIMIT      = 20000;

    typedef struct {
        bit       pixel_on;
        bit [7:0] contrast_level;
    } pixel_result_t;

    // scoreboard: shadow of the controller plus the queue of expected pixel results
    class oled_scoreboard;
        bit [7:0] ram [2048];
        bit [6:0] col_offset, col_ptr;
        bit [3:0] page_ptr;
        bit       vertical, remap, rows_rev, inverted, panel_on;
        bit [7:0] first_line, contrast, pending_op;
        bit       expect_ctrl, cmd_mode, continuous, awaiting;
        pixel_result_t pending_pixels [$];
        int       errors, checked;

        function new();
            foreach (ram[i]) ram[i] = '0;
            col_offset = oled_pkg::COL_OFFSET_RESET;
            contrast = oled_pkg::CONTRAST_RESET;
            expect_ctrl = 1'b1;
        endfunction

        task report(input string what);
            errors++;
            $display("%0t mismatch: %s", $realtime, what);
        endtask

        function void apply_command(input bit [7:0] op, input bit [7:0] arg);
            case (op)
                oled_pkg::OP_CONTRAST:   contrast = arg;
                oled_pkg::OP_DISP_OFF:   panel_on = 1'b0;
                oled_pkg::OP_DISP_ON:    panel_on = 1'b1;
                oled_pkg::OP_NORMAL:     inverted = 1'b0;
                oled_pkg::OP_INVERT:     inverted = 1'b1;
                oled_pkg::OP_PAGE_MODE:  vertical = 1'b0;
                oled_pkg::OP_VERT_MODE:  vertical = 1'b1;
                oled_pkg::OP_SCAN_INC:   rows_rev = 1'b0;
                oled_pkg::OP_SCAN_DEC:   rows_rev = 1'b1;
                oled_pkg::OP_SEG_NORMAL: remap = 1'b0;
                oled_pkg::OP_SEG_REMAP:  remap = 1'b1;
                oled_pkg::OP_START_LINE: first_line = arg;
                default: begin
                    if (op <= 8'h0f)
                        col_ptr[3:0] = op[3:0];
                    else if (op >= OP_COL_HIGH && op <= 8'h17)
                        col_ptr[6:4] = op[2:0];
                    else if (op[7:4] == OP_PAGE_BASE[7:4])
                        page_ptr = op[3:0];
                end
            endcase
        endfunction

        // advance the shadow state by one accepted item
        function void note_item(input bit [1:0] req, input bit [7:0] b,
                                input bit [6:0] x, input bit [6:0] y);
            bit [6:0] row, line, col;
            bit       lit;
            pixel_result_t r;
            if (req == oled_pkg::REQ_START) begin
                expect_ctrl = 1'b1;
            end else if (req == oled_pkg::REQ_WRITE) begin
                if (expect_ctrl) begin
                    cmd_mode = !b[6];
                    continuous = !b[7];
                    expect_ctrl = 1'b0;
                    return;
                end
                if (cmd_mode) begin
                    if (awaiting) begin
                        awaiting = 1'b0;
                        apply_command(pending_op, b);
                    end else if (oled_pkg::takes_param(b)) begin
                        pending_op = b;
                        awaiting = 1'b1;
                        return;
                    end else begin
                        apply_command(b, 8'h00);
                    end
                end else begin
                    col = remap ? 7'd127 - col_ptr : col_ptr;
                    ram[{page_ptr, col}] = b;
                    if (!vertical) begin
                        col_ptr++;
                    end else begin
                        page_ptr++;
                        if (page_ptr == 0) col_ptr++;
                    end
                end
                if (!continuous) expect_ctrl = 1'b1;
            end else if (req == oled_pkg::REQ_READ) begin
                row = y + first_line[6:0];
                line = rows_rev ? 7'd127 - row : row;
                col = x + col_offset;
                lit = ram[{line[6:3], col}][line[2:0]];
                r.pixel_on = (lit != inverted) && panel_on;
                r.contrast_level = contrast;
                pending_pixels.push_back(r);
            end
        endfunction

        task check_result(input bit pixel_on, input bit [7:0] contrast_level);
            pixel_result_t e;
            checked++;
            if (pending_pixels.size() == 0) begin
                report("pixel result with none expected");
                return;
            end
            e = pending_pixels.pop_front();
            if (pixel_on !== e.pixel_on)
                report($sformatf("pixel_on %b, expected %b", pixel_on, e.pixel_on));
            if (contrast_level !== e.contrast_level)
                report($sformatf("contrast_level %0d, expected %0d",
                                 contrast_level, e.contrast_level));
        endtask
    endclass

    logic        aclk, aresetn;
    logic        s_valid, s_ready;
    logic [1:0]  s_req_type;
    logic [7:0]  s_data_byte;
    logic [6:0]  s_pixel_x, s_pixel_y;
    logic        m_valid, m_ready, m_pixel_on;
    logic [7:0]  m_contrast_level;
    logic        psel, penable, pwrite, pready;
    logic [1:0]  paddr;
    logic [31:0] pwdata, prdata;

    oled_scoreboard sb;
    bit quiet;
    int items_sent, idle_cycles, rx_stall;

    monochrome_oled_display_controller i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_data_byte(s_data_byte), .s_pixel_x(s_pixel_x), .s_pixel_y(s_pixel_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_pixel_on(m_pixel_on),
        .m_contrast_level(m_contrast_level),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: check accepted items, stall in random bursts
    always @(posedge aclk) begin
        if (m_valid && m_ready) sb.check_result(m_pixel_on, m_contrast_level);
        if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else if (!quiet && aresetn && $urandom_range(0, 5) == 0) begin
            rx_stall = $urandom_range(0, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
        end
    end

    // watchdog on cycles without any accepted item or apb select
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task send_item(input logic [1:0] req, input logic [7:0] b,
                   input logic [6:0] x, input logic [6:0] y);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_data_byte <= b;
        s_pixel_x <= x;
        s_pixel_y <= y;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(req, b, x, y);
        if (req != REQ_RESERVED) items_sent++;
    endtask

    task send_byte(input logic [7:0] b);
        send_item(oled_pkg::REQ_WRITE, b, 7'($urandom), 7'($urandom));
    endtask

    task send_read(input logic [6:0] x, input logic [6:0] y);
        send_item(oled_pkg::REQ_READ, 8'($urandom), x, y);
    endtask

    // wait for the block to drain, then write the column offset
    task set_column_offset(input logic [6:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_pixels.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_COL_OFFSET;
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.col_offset = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // one command with its parameter where it takes one
    task send_command;
        logic [7:0] op;
        case ($urandom_range(0, 24))
            0, 1:    op = oled_pkg::OP_CONTRAST;
            2:       op = oled_pkg::OP_START_LINE;
            3:       op = oled_pkg::OP_CLKDIV;
            4:       op = oled_pkg::OP_PRECHARGE;
            5:       op = oled_pkg::OP_MUX;
            6:       op = oled_pkg::OP_DCDC;
            7:       op = oled_pkg::OP_OFFSET;
            8:       op = oled_pkg::OP_PINS;
            9:       op = oled_pkg::OP_VCOM;
            10, 11:  op = oled_pkg::OP_DISP_ON;
            12:      op = oled_pkg::OP_DISP_OFF;
            13:      op = oled_pkg::OP_NORMAL;
            14:      op = oled_pkg::OP_INVERT;
            15:      op = oled_pkg::OP_PAGE_MODE;
            16:      op = oled_pkg::OP_VERT_MODE;
            17:      op = oled_pkg::OP_SCAN_INC;
            18:      op = oled_pkg::OP_SCAN_DEC;
            19:      op = oled_pkg::OP_SEG_NORMAL;
            20:      op = oled_pkg::OP_SEG_REMAP;
            21:      op = OP_COL_LOW | 8'($urandom_range(0, 15));
            22:      op = OP_COL_HIGH | 8'($urandom_range(0, 7));
            23:      op = OP_PAGE_BASE | 8'($urandom_range(0, 15));
            default: op = 8'($urandom);
        endcase
        send_byte(op);
        if (oled_pkg::takes_param(op)) send_byte(8'($urandom));
    endtask

    // one random transaction: mostly well-formed, some noise
    task send_transaction;
        bit cont;
        int n;
        cont = $urandom_range(0, 3) != 0;
        n = cont ? $urandom_range(1, 6) : 1;
        case ($urandom_range(0, 9))
            0: send_item(2'($urandom), 8'($urandom), 7'($urandom), 7'($urandom));
            1, 2, 3: begin
                send_item(oled_pkg::REQ_START, 8'($urandom), 7'($urandom), 7'($urandom));
                send_byte((cont ? 8'h00 : CTRL_SINGLE) | 8'($urandom_range(0, 63)));
                repeat (n) send_command();
            end
            4, 5, 6: begin
                send_item(oled_pkg::REQ_START, 8'($urandom), 7'($urandom), 7'($urandom));
                send_byte((cont ? 8'h00 : CTRL_SINGLE) | CTRL_DATA
                          | 8'($urandom_range(0, 63)));
                repeat (n) send_byte(8'($urandom));
            end
            default: repeat ($urandom_range(1, 4)) send_read(7'($urandom), 7'($urandom));
        endcase
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = oled_pkg::REQ_START;
        s_data_byte = '0;
        s_pixel_x = '0;
        s_pixel_y = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_COL_OFFSET;
        pwdata = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reads of the cleared ram, a set of commands, data, edge cases
        send_read(7'd0, 7'd0);
        send_item(oled_pkg::REQ_START, 8'h00, 7'd0, 7'd0);
        send_byte(8'h00);
        send_byte(oled_pkg::OP_DISP_ON);
        send_byte(oled_pkg::OP_INVERT);
        send_read(7'd127, 7'd127);
        send_byte(oled_pkg::OP_NORMAL);
        send_byte(oled_pkg::OP_CONTRAST);
        send_byte(8'hff);
        send_byte(oled_pkg::OP_SCAN_DEC);
        send_byte(oled_pkg::OP_SEG_REMAP);
        send_byte(oled_pkg::OP_VERT_MODE);
        send_byte(8'he3);
        send_byte(OP_PAGE_BASE | 8'h0f);
        send_byte(OP_COL_HIGH | 8'h07);
        send_byte(8'h0f);
        // data past the last page wraps the vertical pointer
        send_item(oled_pkg::REQ_START, 8'h00, 7'd0, 7'd0);
        send_byte(CTRL_DATA);
        send_byte(8'hff);
        send_byte(8'ha5);
        send_read(7'd127, 7'd0);
        // start while a parameter is pending, then the parameter arrives
        send_item(oled_pkg::REQ_START, 8'h00, 7'd0, 7'd0);
        send_byte(CTRL_SINGLE);
        send_byte(oled_pkg::OP_CONTRAST);
        send_item(oled_pkg::REQ_START, 8'h00, 7'd0, 7'd0);
        send_byte(8'h00);
        send_byte(8'h00);
        send_item(REQ_RESERVED, 8'hff, 7'd127, 7'd127);
        send_read(7'd64, 7'd1);

        // random phases across column offset settings
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_column_offset(7'd0);
                1: set_column_offset(7'd127);
                2: set_column_offset(7'($urandom));
                default: set_column_offset(oled_pkg::COL_OFFSET_RESET);
            endcase
            while (items_sent < 238 * (phase + 1)) begin
                if (phase == 3 && items_sent > 850) quiet = 1'b1;
                send_transaction();
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_pixels.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.pending_pixels.size() != 0) sb.report("expected pixel results left over");
        $display("sent %0d items over four column offsets, checked %0d pixel results",
                 items_sent, sb.checked);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
